// ----- hw/rtl/pkcs7u_pkg.sv -----
// Shared types and constants for the PKCS7 padding removal stream block.
// Used by pkcs7u_outreg and pkcs7_unpad_stream; no dependencies.
package pkcs7u_pkg;

  localparam int MAX_BLOCK = 16;
  localparam int MAX_LOG   = $clog2(MAX_BLOCK);
  localparam int ADDR_W    = $clog2(MAX_BLOCK);
  localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
  localparam int LEN_W     = 16;

  // Configuration register indexes
  localparam logic CFG_BLOCK_LOG2 = 1'b0;
  localparam logic CFG_DEST_CAP   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_CAP = 2'd1;
  localparam logic [1:0] ST_PAD = 2'd2;

  typedef struct packed {
    logic [7:0]       data;
    logic             bvalid;
    logic             done;
    logic [1:0]       status;
    logic [LEN_W-1:0] mlen;
  } pu_item_t;

endpackage

// ----- hw/rtl/pkcs7u_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module pkcs7u_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hw/rtl/pkcs7u_outreg.sv -----
// Output register for result items: holds one item until the sink takes it.
// Depends on pkcs7u_pkg.
module pkcs7u_outreg
  import pkcs7u_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     ld,
  input  pu_item_t ld_item,
  input  logic     out_ready,
  output logic     out_valid,
  output pu_item_t item,
  output logic     slot_free
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && slot_free) begin
      item <= ld_item;
    end
  end

endmodule

// ----- hw/rtl/pkcs7_unpad_stream.sv -----
// PKCS7 padding removal over a byte stream: sequencer, counters and delay store.
// Depends on pkcs7u_pkg, pkcs7u_ram and pkcs7u_outreg.
//
// One padded byte is taken per input item. The newest block of bytes waits in a
// 16-entry ring RAM; the byte pushed out of it is emitted while fewer than
// dest_capacity bytes have gone out. A non-final item is pushed into the store,
// after a read and pop of the oldest byte when the store is full; every store
// access goes through the single RAM port, one access per cycle. The final item
// checks the padding with one RAM read per pad byte before the last and emits
// the block's message bytes that fit under dest_capacity with one read each,
// waiting while the sink stalls. The last result carries done_res, status (padding
// error over capacity error) and message_length. No clearing pass after reset.
module pkcs7_unpad_stream
  import pkcs7u_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             is_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             done_res,
  output logic [1:0]       status,
  output logic [LEN_W-1:0] message_length
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_POPRD    = 4'd1;
  localparam logic [3:0] S_POP      = 4'd2;
  localparam logic [3:0] S_PUSH     = 4'd3;
  localparam logic [3:0] S_CHK_INIT = 4'd4;
  localparam logic [3:0] S_CHK_RD   = 4'd5;
  localparam logic [3:0] S_CHK_CMP  = 4'd6;
  localparam logic [3:0] S_EM_INIT  = 4'd7;
  localparam logic [3:0] S_EM_POP   = 4'd8;
  localparam logic [3:0] S_EM_RD    = 4'd9;
  localparam logic [3:0] S_EM_OUT   = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  logic [3:0]        state, state_next;
  logic [2:0]        blk_log2;
  logic [LEN_W-1:0]  capacity;
  logic [CNT_W-1:0]  bsz, bsz_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [ADDR_W-1:0] wp, wp_next;
  logic [LEN_W-1:0]  total, total_next;
  logic [LEN_W-1:0]  written, written_next;
  logic [7:0]        byte_r, byte_r_next;
  logic              last_r, last_r_next;
  logic [7:0]        popped, popped_next;
  logic              pe, pe_next;
  logic              perr, perr_next;
  logic [CNT_W-1:0]  jj, jj_next;
  logic [CNT_W-1:0]  lim, lim_next;
  logic [CNT_W-1:0]  msg, msg_next;
  logic [CNT_W-1:0]  nblk, nblk_next;
  logic              any, any_next;
  logic [1:0]        stat, stat_next;
  logic [LEN_W-1:0]  mlen, mlen_next;

  logic [2:0]        b_log_cfg;
  logic [CNT_W-1:0]  b_cfg;
  logic [CNT_W-1:0]  fill_cl;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_rdata;
  logic              ld, slot_free;
  pu_item_t          ld_item, item;
  logic [LEN_W-1:0]  room, mlen_raw;
  logic              cerr, emit;

  assign in_ready  = (state == S_IDLE);
  assign b_log_cfg = (blk_log2 > 3'(MAX_LOG)) ? 3'(MAX_LOG) : blk_log2;
  assign b_cfg     = CNT_W'(1) << b_log_cfg;
  assign fill_cl   = (fill > b_cfg) ? b_cfg : fill;
  assign emit      = (written < capacity);

  // Store accesses: one per cycle through the single RAM port
  always_comb begin
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = wp;
    case (state)
      S_POPRD: begin
        ram_re   = 1'b1;
        ram_addr = wp - fill[ADDR_W-1:0];
      end
      S_PUSH: begin
        ram_we   = 1'b1;
        ram_addr = wp;
      end
      S_CHK_RD: begin
        ram_re   = (jj < lim);
        ram_addr = wp - ADDR_W'(1) - jj[ADDR_W-1:0];
      end
      S_EM_RD: begin
        ram_re   = (jj < nblk);
        ram_addr = wp - fill[ADDR_W-1:0] + jj[ADDR_W-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    room     = emit ? (capacity - written) : '0;
    mlen_raw = (total > LEN_W'(byte_r)) ? (total - LEN_W'(byte_r)) : '0;
    cerr     = (mlen_raw > capacity);
  end

  always_comb begin
    state_next   = state;
    bsz_next     = bsz;
    fill_next    = fill;
    wp_next      = wp;
    total_next   = total;
    written_next = written;
    byte_r_next  = byte_r;
    last_r_next  = last_r;
    popped_next  = popped;
    pe_next      = pe;
    perr_next    = perr;
    jj_next      = jj;
    lim_next     = lim;
    msg_next     = msg;
    nblk_next    = nblk;
    any_next     = any;
    stat_next    = stat;
    mlen_next    = mlen;
    ld           = 1'b0;
    ld_item      = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          byte_r_next = in_byte;
          last_r_next = is_last;
          bsz_next    = b_cfg;
          fill_next   = fill_cl;   // drop bytes older than the current block
          pe_next     = 1'b0;
          state_next  = (fill_cl == b_cfg) ? S_POPRD : S_PUSH;
        end
      end
      S_POPRD: begin
        state_next = S_POP;
      end
      S_POP: begin
        // Hold while a non-final pushed-out byte cannot be placed
        if (last_r || !emit || slot_free) begin
          fill_next = fill - CNT_W'(1);
          if (emit) begin
            written_next = written + LEN_W'(1);
          end
          if (last_r) begin
            popped_next = ram_rdata;
            pe_next     = emit;
          end else if (emit) begin
            ld             = 1'b1;
            ld_item.data   = ram_rdata;
            ld_item.bvalid = 1'b1;
          end
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        wp_next   = wp + ADDR_W'(1);
        fill_next = fill + CNT_W'(1);
        if (total != LEN_MAX) begin
          total_next = total + LEN_W'(1);
        end
        state_next = last_r ? S_CHK_INIT : S_IDLE;
      end
      S_CHK_INIT: begin
        perr_next = (byte_r == 8'd0) || (byte_r > 8'(bsz)) ||
                    ((total & LEN_W'(bsz - CNT_W'(1))) != '0);
        lim_next  = (byte_r >= 8'(fill)) ? fill : byte_r[CNT_W-1:0];
        msg_next  = (byte_r >= 8'(fill)) ? '0 : (fill - byte_r[CNT_W-1:0]);
        jj_next   = CNT_W'(1);
        state_next = S_CHK_RD;
      end
      S_CHK_RD: begin
        state_next = (jj < lim) ? S_CHK_CMP : S_EM_INIT;
      end
      S_CHK_CMP: begin
        if (ram_rdata != byte_r) begin
          perr_next = 1'b1;
        end
        jj_next    = jj + CNT_W'(1);
        state_next = S_CHK_RD;
      end
      S_EM_INIT: begin
        nblk_next  = (LEN_W'(msg) > room) ? room[CNT_W-1:0] : msg;
        mlen_next  = cerr ? capacity : mlen_raw;
        stat_next  = perr ? ST_PAD : (cerr ? ST_CAP : ST_OK);
        jj_next    = '0;
        any_next   = 1'b0;
        state_next = S_EM_POP;
      end
      S_EM_POP: begin
        if (!pe) begin
          state_next = S_EM_RD;
        end else if (slot_free) begin
          ld             = 1'b1;
          ld_item.data   = popped;
          ld_item.bvalid = 1'b1;
          if (nblk == '0) begin
            ld_item.done   = 1'b1;
            ld_item.status = stat;
            ld_item.mlen   = mlen;
          end
          any_next   = 1'b1;
          pe_next    = 1'b0;
          state_next = S_EM_RD;
        end
      end
      S_EM_RD: begin
        if (jj < nblk) begin
          state_next = S_EM_OUT;
        end else if (any) begin
          state_next = S_FIN;
        end else if (slot_free) begin
          // Nothing emitted: send a bare status item
          ld             = 1'b1;
          ld_item.done   = 1'b1;
          ld_item.status = stat;
          ld_item.mlen   = mlen;
          state_next     = S_FIN;
        end
      end
      S_EM_OUT: begin
        if (slot_free) begin
          ld             = 1'b1;
          ld_item.data   = ram_rdata;
          ld_item.bvalid = 1'b1;
          if (jj == nblk - CNT_W'(1)) begin
            ld_item.done   = 1'b1;
            ld_item.status = stat;
            ld_item.mlen   = mlen;
          end
          written_next = written + LEN_W'(1);
          any_next     = 1'b1;
          jj_next      = jj + CNT_W'(1);
          state_next   = S_EM_RD;
        end
      end
      S_FIN: begin
        fill_next    = '0;
        total_next   = '0;
        written_next = '0;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      total    <= '0;
      written  <= '0;
      wp       <= '0;
      pe       <= 1'b0;
      any      <= 1'b0;
      blk_log2 <= 3'(MAX_LOG);
      capacity <= LEN_MAX;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      total   <= total_next;
      written <= written_next;
      wp      <= wp_next;
      pe      <= pe_next;
      any     <= any_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_LOG2: blk_log2 <= cfg_wdata[2:0];
          CFG_DEST_CAP:   capacity <= cfg_wdata;
          default:        capacity <= capacity;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bsz    <= bsz_next;
    byte_r <= byte_r_next;
    last_r <= last_r_next;
    popped <= popped_next;
    perr   <= perr_next;
    jj     <= jj_next;
    lim    <= lim_next;
    msg    <= msg_next;
    nblk   <= nblk_next;
    stat   <= stat_next;
    mlen   <= mlen_next;
  end

  pkcs7u_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BLOCK)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(byte_r),
    .rdata(ram_rdata)
  );

  pkcs7u_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .ld_item  (ld_item),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .item     (item),
    .slot_free(slot_free)
  );

  assign out_byte       = item.data;
  assign byte_valid     = item.bvalid;
  assign done_res       = item.done;
  assign status         = item.status;
  assign message_length = item.mlen;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_BLOCK))
    else $error("store fill count exceeds block store depth");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer stayed ready after taking an item");

  a_bare_is_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> done_res)
    else $error("result without a byte is not the final result");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (fill == '0 && total == '0 && written == '0))
    else $error("counts not cleared after the final item");

  a_no_load_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_byte) && $stable(done_res)))
    else $error("pending result overwritten while stalled");

endmodule
